// File: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: src/mamed_pkg.sv
`timescale 1ns / 1ps

package mamed_pkg;

   // commands from the sequencer to the row of median cells
   typedef struct packed {
      logic insert;   // replace the oldest entry (or fill the next empty cell)
      logic step;     // one odd-even compare-exchange pass
      logic phase;    // which neighbor pairs exchange in this pass
      logic capture;  // register the element at the median rank
   } mamed_ctl_type;

endpackage

// File: src/mamed_div.sv
`timescale 1ns / 1ps

module mamed_div #(
   parameter int DIVIDEND_BITS = 19,
   parameter int DIVISOR_BITS  = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [DIVIDEND_BITS-1:0] dividend,
   input  logic [DIVISOR_BITS-1:0]  divisor,
   output logic                     done,
   output logic [DIVIDEND_BITS-1:0] quotient
);

   localparam int REM_W = DIVISOR_BITS + 1;
   localparam int CNT_W = $clog2(DIVIDEND_BITS + 1);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [DIVIDEND_BITS-1:0] quo_ff, quo_in;
   logic [DIVISOR_BITS-1:0]  rem_ff, rem_in;
   logic [DIVISOR_BITS-1:0]  dvs_ff, dvs_in;
   logic [REM_W-1:0]         trial;
   logic [REM_W-1:0]         diff;
   logic                     fits;

   // restoring division, one quotient bit per cycle, msb first
   always_comb begin
      trial = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = (trial >= {1'b0, dvs_ff});

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIVIDEND_BITS-2:0], fits};
         // the partial remainder always stays below the divisor
         rem_in = fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(DIVIDEND_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: src/mamed_cell.sv
`timescale 1ns / 1ps

module mamed_cell #(
   parameter int INDEX      = 0,
   parameter int DEPTH      = 100,
   parameter int VALUE_BITS = 16,
   parameter int AGE_W      = 7,
   parameter int CELL_W     = 1 + 7 + 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mamed_pkg::mamed_ctl_type ctl,
   input  logic [VALUE_BITS-1:0]   new_value,
   input  logic [AGE_W-1:0]        fill,
   input  logic [CELL_W-1:0]       left_state,
   input  logic [CELL_W-1:0]       right_state,
   output logic [CELL_W-1:0]       cell_state
);

   import mamed_pkg::*;

   localparam bit HAS_LEFT  = (INDEX > 0);
   localparam bit HAS_RIGHT = (INDEX < DEPTH - 1);
   localparam bit PARITY    = 1'(INDEX % 2);

   logic                  valid_ff, valid_in;
   logic [AGE_W-1:0]      age_ff, age_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic                  left_valid, right_valid;
   logic [VALUE_BITS-1:0] left_value, right_value;
   logic                  target;

   // empty cells sort above every stored value
   function automatic logic is_greater(input logic a_valid, input logic [VALUE_BITS-1:0] a_val,
                                       input logic b_valid, input logic [VALUE_BITS-1:0] b_val);
      is_greater = (!a_valid && b_valid) || (a_valid && b_valid && (a_val > b_val));
   endfunction

   assign left_valid  = left_state[CELL_W-1];
   assign left_value  = left_state[VALUE_BITS-1:0];
   assign right_valid = right_state[CELL_W-1];
   assign right_value = right_state[VALUE_BITS-1:0];

   // the oldest entry when full, otherwise the first empty cell
   assign target = (valid_ff && (age_ff == AGE_W'(DEPTH - 1)))
                || (!valid_ff && (fill == AGE_W'(INDEX)));

   always_comb begin
      valid_in = valid_ff;
      age_in   = age_ff;
      value_in = value_ff;
      if (ctl.insert) begin
         if (target) begin
            valid_in = 1'b1;
            age_in   = '0;
            value_in = new_value;
         end else if (valid_ff) begin
            age_in = age_ff + 1'b1;
         end
      end else if (ctl.step) begin
         if (HAS_RIGHT && (ctl.phase == PARITY)
             && is_greater(valid_ff, value_ff, right_valid, right_value)) begin
            {valid_in, age_in, value_in} = right_state;
         end else if (HAS_LEFT && (ctl.phase != PARITY)
                      && is_greater(left_valid, left_value, valid_ff, value_ff)) begin
            {valid_in, age_in, value_in} = left_state;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      age_ff   <= age_in;
      value_ff <= value_in;
   end

   assign cell_state = {valid_ff, age_ff, value_ff};

endmodule

// File: src/mamed_chain.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mamed_chain #(
   parameter int DEPTH      = 100,
   parameter int VALUE_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  mamed_pkg::mamed_ctl_type ctl,
   input  logic [VALUE_BITS-1:0]    new_value,
   output logic [VALUE_BITS-1:0]    median
);

   import mamed_pkg::*;

   localparam int AGE_W  = $clog2(DEPTH + 1);
   localparam int CELL_W = 1 + AGE_W + VALUE_BITS;

   logic [CELL_W-1:0]     state_w [DEPTH];
   logic [DEPTH-1:0]      valid_vec;
   logic [AGE_W-1:0]      fill_ff, fill_in;
   logic [AGE_W-1:0]      mid_rank;
   logic [VALUE_BITS-1:0] median_ff, median_in;
   logic [VALUE_BITS-1:0] pick;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [CELL_W-1:0] left_w;
      logic [CELL_W-1:0] right_w;
      if (i == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_inner_l
         assign left_w = state_w[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_inner_r
         assign right_w = state_w[i+1];
      end
      mamed_cell #(
         .INDEX      (i),
         .DEPTH      (DEPTH),
         .VALUE_BITS (VALUE_BITS),
         .AGE_W      (AGE_W),
         .CELL_W     (CELL_W)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .new_value   (new_value),
         .fill        (fill_ff),
         .left_state  (left_w),
         .right_state (right_w),
         .cell_state  (state_w[i])
      );
      assign valid_vec[i] = state_w[i][CELL_W-1];
   end

   always_comb begin
      fill_in = fill_ff;
      if (ctl.insert && (fill_ff != AGE_W'(DEPTH))) begin
         fill_in = fill_ff + 1'b1;
      end
   end

   // upper median: rank fill/2 of the sorted row
   assign mid_rank = fill_ff >> 1;

   always_comb begin
      pick = '0;
      for (int i = 0; i < DEPTH; i++) begin
         if (mid_rank == AGE_W'(i)) begin
            pick = pick | state_w[i][VALUE_BITS-1:0];
         end
      end
   end

   assign median_in = ctl.capture ? pick : median_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      median_ff <= median_in;
   end

   assign median = median_ff;

   `ASSERT_IMPLIES(a_fill_matches_cells, clock, reset, 1'b1, $countones(valid_vec) == fill_ff)
   `ASSERT_NEXT(a_insert_fills, clock, reset, ctl.insert, fill_ff != '0)
   `ASSERT_IMPLIES(a_one_command, clock, reset, 1'b1, $onehot0({ctl.insert, ctl.step, ctl.capture}))

endmodule

// File: src/moving_average_then_running_median.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Frame-time smoother: each sample beat updates a moving average over the last
// AVERAGE_DEPTH samples (sum divided by the current fill, truncated), and that mean
// enters a window of the last MEDIAN_DEPTH means kept sorted in a row of cells; the
// result beat carries the upper median of that window and the mean itself. One sample
// is in work at a time: a bit-serial divider develops the SUM_BITS quotient bits of the
// mean (SUM_BITS = SAMPLE_BITS + log2(AVERAGE_DEPTH)), then the cell row runs
// MEDIAN_DEPTH odd-even exchange passes. A finished result waits in the output register
// while the next sample is taken. No clearing pass is needed after reset.
module moving_average_then_running_median #(
   parameter int AVERAGE_DEPTH = 8,
   parameter int MEDIAN_DEPTH  = 100,
   parameter int SAMPLE_BITS   = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [SAMPLE_BITS-1:0] req_sample_time,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [SAMPLE_BITS-1:0] rsp_filtered_time,
   output logic [SAMPLE_BITS-1:0] rsp_average_time
);

   import mamed_pkg::*;

   localparam int FILL_W = $clog2(AVERAGE_DEPTH + 1);
   localparam int SUM_W  = SAMPLE_BITS + $clog2(AVERAGE_DEPTH);
   localparam int SORT_W = $clog2(MEDIAN_DEPTH + 1);

   typedef enum logic [2:0] {
      IDLE, LOAD, DIVIDE, INSERT, SORT, SELECT, EMIT
   } state_type;

   state_type             state_ff;
   logic [SORT_W-1:0]     sort_cnt_ff;
   logic [SAMPLE_BITS-1:0] mean_ff;
   logic                  rsp_valid_ff;
   logic [SAMPLE_BITS-1:0] rsp_filtered_ff;
   logic [SAMPLE_BITS-1:0] rsp_average_ff;

   logic [SAMPLE_BITS-1:0] taps_ff [AVERAGE_DEPTH];
   logic [FILL_W-1:0]      avg_fill_ff, avg_fill_in;
   logic [SUM_W-1:0]       avg_sum_ff, avg_sum_in;

   logic              accept;
   logic              div_done;
   logic [SUM_W-1:0]  div_quotient;
   mamed_ctl_type     ctl;
   logic [SAMPLE_BITS-1:0] median;

   assign req_ready = (state_ff == IDLE);
   assign accept    = req_valid && req_ready;

   // running sum: drop the oldest tap once the window is full
   always_comb begin
      avg_fill_in = avg_fill_ff;
      avg_sum_in  = avg_sum_ff;
      if (accept) begin
         if (avg_fill_ff == FILL_W'(AVERAGE_DEPTH)) begin
            avg_sum_in = avg_sum_ff - SUM_W'(taps_ff[AVERAGE_DEPTH-1])
                       + SUM_W'(req_sample_time);
         end else begin
            avg_sum_in  = avg_sum_ff + SUM_W'(req_sample_time);
            avg_fill_in = avg_fill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_fill_ff <= '0;
         avg_sum_ff  <= '0;
      end else begin
         avg_fill_ff <= avg_fill_in;
         avg_sum_ff  <= avg_sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         taps_ff[0] <= req_sample_time;
         for (int i = 1; i < AVERAGE_DEPTH; i++) begin
            taps_ff[i] <= taps_ff[i-1];
         end
      end
   end

   mamed_div #(
      .DIVIDEND_BITS (SUM_W),
      .DIVISOR_BITS  (FILL_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (state_ff == LOAD),
      .dividend (avg_sum_ff),
      .divisor  (avg_fill_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      ctl.insert  = (state_ff == INSERT);
      ctl.step    = (state_ff == SORT);
      ctl.phase   = sort_cnt_ff[0];
      ctl.capture = (state_ff == SELECT);
   end

   mamed_chain #(
      .DEPTH      (MEDIAN_DEPTH),
      .VALUE_BITS (SAMPLE_BITS)
   ) u_chain (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .new_value (mean_ff),
      .median    (median)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         sort_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // output register free or being emptied this cycle
         if ((state_ff == EMIT) && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (accept) begin
                  state_ff <= LOAD;
               end
            end
            LOAD: begin
               state_ff <= DIVIDE;
            end
            DIVIDE: begin
               if (div_done) begin
                  mean_ff  <= div_quotient[SAMPLE_BITS-1:0];
                  state_ff <= INSERT;
               end
            end
            INSERT: begin
               sort_cnt_ff <= '0;
               state_ff    <= SORT;
            end
            SORT: begin
               sort_cnt_ff <= sort_cnt_ff + 1'b1;
               if (sort_cnt_ff == SORT_W'(MEDIAN_DEPTH - 1)) begin
                  state_ff <= SELECT;
               end
            end
            SELECT: begin
               state_ff <= EMIT;
            end
            EMIT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_filtered_ff <= median;
                  rsp_average_ff  <= mean_ff;
                  state_ff        <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_filtered_time = rsp_filtered_ff;
   assign rsp_average_time  = rsp_average_ff;

   `ASSERT_IMPLIES(a_div_done_in_divide, clock, reset, div_done, state_ff == DIVIDE)
   `ASSERT_NEXT(a_emit_delivers, clock, reset, (state_ff == EMIT) && (!rsp_valid_ff || rsp_ready), rsp_valid && (state_ff == IDLE))
   `ASSERT_IMPLIES(a_fill_nonzero_in_work, clock, reset, (state_ff == LOAD) || (state_ff == DIVIDE), avg_fill_ff != '0)

endmodule

// File: tb/sv/frame_time_checker.sv
`timescale 1ns / 1ps

module frame_time_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [15:0] req_sample_time,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [15:0] rsp_filtered_time,
   input  logic [15:0] rsp_average_time,
   output int          error_count,
   output int          pending_count
);

   localparam int AVG_LEN = 8;
   localparam int MED_LEN = 100;
   localparam int EXPECT_SLOTS = 16;

   typedef struct packed {
      logic [15:0] filtered;
      logic [15:0] average;
   } smoothed_type;

   logic [15:0]  recent_samples [AVG_LEN];
   int           sample_fill;
   logic [18:0]  sample_sum;
   int           sample_slot;
   logic [15:0]  recent_means [MED_LEN];
   int           mean_fill;
   int           mean_slot;
   smoothed_type expect_ring [EXPECT_SLOTS];
   int           expect_head;
   int           expect_tail;
   int           mismatches;

   // push one sample through both windows, return the beat the block should send
   function automatic smoothed_type smooth_sample(input logic [15:0] sample);
      smoothed_type r;
      int below;
      int at_most;
      int rank;
      logic found;
      if (sample_fill == AVG_LEN)
         sample_sum = sample_sum - recent_samples[sample_slot];
      else
         sample_fill++;
      recent_samples[sample_slot] = sample;
      sample_sum = sample_sum + sample;
      sample_slot = (sample_slot + 1) % AVG_LEN;
      r.average = 16'(sample_sum / sample_fill);

      recent_means[mean_slot] = r.average;
      if (mean_fill < MED_LEN)
         mean_fill++;
      mean_slot = (mean_slot + 1) % MED_LEN;

      // upper median by rank counting, duplicates included
      rank = mean_fill / 2;
      r.filtered = '0;
      found = 1'b0;
      for (int i = 0; i < mean_fill && !found; i++) begin
         below = 0;
         at_most = 0;
         for (int j = 0; j < mean_fill; j++) begin
            if (recent_means[j] < recent_means[i])
               below++;
            if (recent_means[j] <= recent_means[i])
               at_most++;
         end
         if (below <= rank && rank < at_most) begin
            r.filtered = recent_means[i];
            found = 1'b1;
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      smoothed_type want;
      if (reset) begin
         sample_fill = 0;
         sample_sum = '0;
         sample_slot = 0;
         mean_fill = 0;
         mean_slot = 0;
         expect_head = 0;
         expect_tail = 0;
      end else begin
         if (req_valid && req_ready) begin
            if (expect_tail - expect_head == EXPECT_SLOTS) begin
               $display("%0t: too many result beats outstanding", $time);
               mismatches++;
            end else begin
               expect_ring[expect_tail % EXPECT_SLOTS] = smooth_sample(req_sample_time);
               expect_tail++;
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expect_tail == expect_head) begin
               $display("%0t: unexpected result beat: filtered_time %0d average_time %0d",
                  $time, rsp_filtered_time, rsp_average_time);
               mismatches++;
            end else begin
               want = expect_ring[expect_head % EXPECT_SLOTS];
               expect_head++;
               if (rsp_filtered_time !== want.filtered) begin
                  $display("%0t: filtered_time expected %0d actual %0d",
                     $time, want.filtered, rsp_filtered_time);
                  mismatches++;
               end
               if (rsp_average_time !== want.average) begin
                  $display("%0t: average_time expected %0d actual %0d",
                     $time, want.average, rsp_average_time);
                  mismatches++;
               end
            end
         end
      end
      error_count <= mismatches;
      pending_count <= expect_tail - expect_head;
   end

endmodule

// File: tb/sv/moving_average_then_running_median_test.sv
`timescale 1ns / 1ps

module moving_average_then_running_median_test;

   localparam int QUIET_LIMIT = 4000;
   localparam int PHASE_ITEMS = 320;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [15:0] req_sample_time = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_filtered_time;
   logic [15:0] rsp_average_time;

   int error_count;
   int pending_count;
   int idle_pct = 0;
   int stall_pct = 0;
   int quiet_cycles = 0;

   always #5 clock = ~clock;

   moving_average_then_running_median dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample_time   (req_sample_time),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_filtered_time (rsp_filtered_time),
      .rsp_average_time  (rsp_average_time)
   );

   frame_time_checker checker_inst (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample_time   (req_sample_time),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_filtered_time (rsp_filtered_time),
      .rsp_average_time  (rsp_average_time),
      .error_count       (error_count),
      .pending_count     (pending_count)
   );

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_sample(input logic [15:0] sample);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_time <= sample;
      do @(posedge clock); while (!req_ready);
   endtask

   // hold off new samples until every result beat is back
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_count == 0);
   endtask

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(7))
         0: return 16'h0000;
         1: return 16'hffff;
         // tight cluster gives many equal means in the median window
         2, 3: return 16'(16000 + $urandom_range(40));
         4: return 16'(1 << $urandom_range(15));
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      logic [15:0] directed [22] = '{
         16'h0000, 16'h0000,
         16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
         16'hffff,
         16'h0000, 16'hffff, 16'h0000, 16'hffff,
         16'h0001, 16'h8000, 16'h7fff, 16'h5555, 16'haaaa, 16'h0001, 16'h0001
      };
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i])
         send_sample(directed[i]);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct <= 0;  end
            1: begin idle_pct = 65; stall_pct <= 0;  end
            2: begin idle_pct = 0;  stall_pct <= 65; end
            default: begin idle_pct = 18; stall_pct <= 18; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_sample(pick_sample());
            if (n == PHASE_ITEMS / 2)
               drain();
         end
      end

      drain();
      repeat (200) @(posedge clock);
      if (error_count == 0 && pending_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// File: files.f
+incdir+src
src/mamed_pkg.sv
src/mamed_div.sv
src/mamed_cell.sv
src/mamed_chain.sv
src/moving_average_then_running_median.sv
tb/sv/frame_time_checker.sv
tb/sv/moving_average_then_running_median_test.sv
